// ----- design/sfpe_pkg.sv -----
// Package for the sprite frame piece expander: sizes, table entry types, beat types, codes.
package sfpe_pkg;

  localparam int NumAnimations     = 16;
  localparam int NumFrames         = 64;
  localparam int NumPlacements     = 256;
  localparam int NumPieces         = 64;
  localparam int MaxPiecesPerFrame = 64;

  localparam int AnimAw  = $clog2(NumAnimations);
  localparam int FrameAw = $clog2(NumFrames);
  localparam int PlaceAw = $clog2(NumPlacements);
  localparam int PieceAw = $clog2(NumPieces);
  localparam int IdxW    = $clog2(MaxPiecesPerFrame);
  localparam int CntW    = $clog2(MaxPiecesPerFrame + 1);

  localparam int FlipBit   = 0;
  localparam int FlagShift = 4;
  localparam int CfgDataW  = 16;

  typedef enum logic [2:0] {
    CMD_WR_ANIM  = 3'd0,
    CMD_WR_FRAME = 3'd1,
    CMD_WR_PLACE = 3'd2,
    CMD_WR_PIECE = 3'd3,
    CMD_DRAW     = 3'd4
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_SPRITE_FLAGS = 1'b0,
    CFG_IMAGE_BASE   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] start;
    logic [7:0] count;
  } span_t;

  typedef struct packed {
    logic [7:0] piece;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] flags;
  } place_t;

  typedef struct packed {
    logic [7:0]  w;
    logic [7:0]  h;
    logic [15:0] offset;
  } piece_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         entry_index;
    logic [7:0]         link_index;
    logic [7:0]         item_count;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [7:0]         flag_bits;
    logic [7:0]         piece_width;
    logic [7:0]         piece_height;
    logic [15:0]        pix_offset;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]        blit_address;
    logic signed [15:0] blit_x;
    logic signed [15:0] blit_y;
    logic [7:0]         blit_width;
    logic [7:0]         blit_height;
    logic [7:0]         blit_flags;
    logic               last;
  } res_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic write_en;    // accepted table write
    logic capture;     // accepted draw
    logic load_frame;  // frame entry is on the read register
    logic emit;        // placement and piece are on the read registers
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_empty;
    logic last_piece;
  } dp_status_t;

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

endpackage

// ----- design/sfpe_ctrl.sv -----
// Controller state machine: accepts commands and sequences the table read chain of a draw.
module sfpe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0]            cmd_i,
  input  sfpe_pkg::dp_status_t  status_i,
  output sfpe_pkg::ctrl_cmd_t   ctrl_o,
  output logic                  busy_o
);
  import sfpe_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ANIM  = 5'b00010,
    ST_FRAME = 5'b00100,
    ST_PLACE = 5'b01000,
    ST_PIECE = 5'b10000
  } state_e;

  // ST_PIECE waits on the piece read; the emit cycle follows, flagged by emit_q.
  state_e state_q, state_d;
  logic   emit_q, emit_d;
  logic   accept;
  logic   is_draw;

  assign busy_o  = (state_q != ST_IDLE) || emit_q;
  assign accept  = start_i && !busy_o;
  assign is_draw = (cmd_e'(cmd_i) == CMD_DRAW);

  always_comb begin
    state_d = state_q;
    emit_d  = 1'b0;
    ctrl_o  = '0;
    ctrl_o.write_en = accept && !is_draw;
    ctrl_o.capture  = accept && is_draw;
    ctrl_o.emit     = emit_q;
    if (emit_q) begin
      state_d = status_i.last_piece ? ST_IDLE : ST_PLACE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && is_draw) state_d = ST_ANIM;
        end
        ST_ANIM: begin
          state_d = ST_FRAME;
        end
        ST_FRAME: begin
          ctrl_o.load_frame = 1'b1;
          state_d = status_i.frame_empty ? ST_IDLE : ST_PLACE;
        end
        ST_PLACE: begin
          state_d = ST_PIECE;
        end
        ST_PIECE: begin
          emit_d  = 1'b1;
          state_d = ST_PIECE;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

endmodule

// ----- design/sfpe_datapath.sv -----
// Datapath: config registers, the four tables, draw context and the blit result register.
module sfpe_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfpe_pkg::in_beat_t    in_i,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  sfpe_pkg::ctrl_cmd_t   ctrl_i,
  output sfpe_pkg::dp_status_t  status_o,
  output logic                  res_valid_o,
  output sfpe_pkg::res_beat_t   res_o
);
  import sfpe_pkg::*;

  logic [3:0]  sprite_flags_q;
  logic [15:0] image_base_q;

  span_t  anim_mem  [NumAnimations];
  span_t  frame_mem [NumFrames];
  place_t place_mem [NumPlacements];
  piece_t piece_mem [NumPieces];

  span_t  anim_rd_q, frame_rd_q;
  place_t place_rd_q;
  piece_t piece_rd_q;

  logic [7:0]  req_link_q;
  logic [15:0] req_x_q, req_y_q;
  logic        req_flip_q;
  logic [7:0]  base_q;
  logic [CntW-1:0] n_q, n_d;
  logic [IdxW-1:0] idx_q;

  logic [7:0] frame_sum, place_sum;
  logic [FrameAw-1:0] frame_raddr;
  logic [PlaceAw-1:0] place_raddr;
  logic [PieceAw-1:0] piece_raddr;

  res_beat_t res_q, res_d;
  logic      res_valid_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprite_flags_q <= '0;
      image_base_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPRITE_FLAGS: sprite_flags_q <= cfg_data_i[3:0];
        CFG_IMAGE_BASE:   image_base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // read addresses, all wrapping at table depth
  assign frame_sum   = anim_rd_q.start + req_link_q;
  assign frame_raddr = frame_sum[FrameAw-1:0];
  assign place_sum   = base_q + 8'(idx_q);
  assign place_raddr = place_sum[PlaceAw-1:0];
  assign piece_raddr = place_rd_q.piece[PieceAw-1:0];

  // tables: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_en && cmd_e'(in_i.cmd) == CMD_WR_ANIM)
      anim_mem[in_i.entry_index[AnimAw-1:0]] <= '{start: in_i.link_index,
                                                   count: in_i.item_count};
    anim_rd_q <= anim_mem[in_i.entry_index[AnimAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_en && cmd_e'(in_i.cmd) == CMD_WR_FRAME)
      frame_mem[in_i.entry_index[FrameAw-1:0]] <= '{start: in_i.link_index,
                                                     count: in_i.item_count};
    frame_rd_q <= frame_mem[frame_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_en && cmd_e'(in_i.cmd) == CMD_WR_PLACE)
      place_mem[in_i.entry_index[PlaceAw-1:0]] <= '{piece: in_i.link_index,
                                                     dx:    in_i.coord_x[7:0],
                                                     dy:    in_i.coord_y[7:0],
                                                     flags: in_i.flag_bits};
    place_rd_q <= place_mem[place_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_en && cmd_e'(in_i.cmd) == CMD_WR_PIECE)
      piece_mem[in_i.entry_index[PieceAw-1:0]] <= '{w:      in_i.piece_width,
                                                     h:      in_i.piece_height,
                                                     offset: in_i.pix_offset};
    piece_rd_q <= piece_mem[piece_raddr];
  end

  // piece count, clamped
  assign n_d = (frame_rd_q.count > 8'(MaxPiecesPerFrame)) ? CntW'(MaxPiecesPerFrame)
                                                          : CntW'(frame_rd_q.count);

  assign status_o.frame_empty = (frame_rd_q.count == 8'd0);
  assign status_o.last_piece  = ({1'b0, idx_q} == (n_q - CntW'(1)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      req_link_q <= in_i.link_index;
      req_x_q    <= in_i.coord_x;
      req_y_q    <= in_i.coord_y;
      req_flip_q <= in_i.flag_bits[FlipBit];
    end
    if (ctrl_i.load_frame) begin
      base_q <= frame_rd_q.start;
      n_q    <= n_d;
      idx_q  <= '0;
    end else if (ctrl_i.emit) begin
      idx_q  <= idx_q + IdxW'(1);
    end
  end

  // blit computation
  always_comb begin
    logic [15:0] dx;
    logic [7:0]  pf;
    dx = sext8(place_rd_q.dx);
    pf = place_rd_q.flags;
    if (req_flip_q) begin
      dx = 16'd0 - dx - {8'd0, piece_rd_q.w} + 16'd1;
      pf[FlipBit] = ~pf[FlipBit];
    end
    pf = pf | {sprite_flags_q, 4'd0};
    res_d.blit_address = image_base_q + piece_rd_q.offset;
    res_d.blit_x       = req_x_q + dx;
    res_d.blit_y       = req_y_q + sext8(place_rd_q.dy);
    res_d.blit_width   = piece_rd_q.w;
    res_d.blit_height  = piece_rd_q.h;
    res_d.blit_flags   = pf;
    res_d.last         = status_o.last_piece;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else         res_valid_q <= ctrl_i.emit;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- design/sprite_frame_piece_expander_top.sv -----
// Top level of the sprite frame piece expander: controller plus datapath.
//
// A command beat is taken when start_i is high and busy_o is low. Table writes
// (animation, frame, placement, piece) give no result. A draw chains registered
// reads through the tables: animation entry, frame entry, then for each piece a
// placement read, a piece read and an emit cycle. busy_o stays high from the
// animation read to the last emit (to the frame read for an empty frame). A
// piece's reads start only after the previous piece is emitted, as each table has
// a single read port and the piece read depends on the placement read. Each blit
// beat is on res_o for exactly one cycle under res_valid_o; the last beat of a
// draw carries last. The receiver cannot stall, so every strobed beat must be
// taken when shown. Frames longer than 64 placements emit only their first 64.
// The user writes configuration (sprite flags, image base) through cfg_we_i only
// while the block is idle and the last result has been shown; the block does not
// enforce it. Tables come up undefined; draw only from written entries.
module sprite_frame_piece_expander_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  sfpe_pkg::in_beat_t    in_i,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output logic                  res_valid_o,
  output sfpe_pkg::res_beat_t   res_o
);
  import sfpe_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  sfpe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (in_i.cmd),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy_o)
  );

  sfpe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
